// ----- sv/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/afrc_pkg.sv -----
// ----------------------------------------------------------------------------
// afrc_pkg
// types and constants of the api frame receiver with checksum check
// ----------------------------------------------------------------------------
package afrc_pkg;

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_LEN_HI  = 4'd1;
  localparam logic [3:0] PH_LEN_LO  = 4'd2;
  localparam logic [3:0] PH_API     = 4'd3;
  localparam logic [3:0] PH_ID      = 4'd4;
  localparam logic [3:0] PH_DEST_HI = 4'd5;
  localparam logic [3:0] PH_DEST_LO = 4'd6;
  localparam logic [3:0] PH_OPT     = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CHECK   = 4'd9;

  localparam logic [7:0]  START_BYTE = 8'h7E;
  localparam logic [7:0]  SUM_BASE   = 8'hFF;
  localparam logic [15:0] HEADER_LEN = 16'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  api_id;
    logic [7:0]  frame_id;
    logic [15:0] dest_addr;
    logic [7:0]  options;
    logic [15:0] frame_length;
    logic        checksum_ok;
  } result_t;

endpackage

// ----- sv/api_frame_receiver_checksum.sv -----
// ----------------------------------------------------------------------------
// api_frame_receiver_checksum
// serial api frame receiver: streams payload bytes, checks the frame checksum
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  rx      | rx_valid / rx_ready | rx_byte
//  res     | res_valid/res_ready | kind, data_byte, api_id, frame_id,
//          |                     | dest_addr, options, frame_length, checksum_ok
//
//  one byte per cycle while the output register is empty or being drained; the
//  result of a byte is in the output register the cycle after its transaction
//  rx_ready is high whenever the output register is empty or being drained
//  rst clears the frame state to hunting and empties the output register
//  header bytes and bytes dropped while hunting give no result
module api_frame_receiver_checksum
  import afrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  api_id,
  output logic [7:0]  frame_id,
  output logic [15:0] dest_addr,
  output logic [7:0]  options,
  output logic [15:0] frame_length,
  output logic        checksum_ok
);

  logic    step;
  logic    emit;
  result_t res;
  result_t res_q;

  assign rx_ready = !res_valid || res_ready;
  assign step     = rx_valid && rx_ready;

  afrc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx_byte),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_q <= res;
    end
  end

  assign kind         = res_q.kind;
  assign data_byte    = res_q.data_byte;
  assign api_id       = res_q.api_id;
  assign frame_id     = res_q.frame_id;
  assign dest_addr    = res_q.dest_addr;
  assign options      = res_q.options;
  assign frame_length = res_q.frame_length;
  assign checksum_ok  = res_q.checksum_ok;

endmodule

// ----- sv/afrc_parser.sv -----
// ----------------------------------------------------------------------------
// afrc_parser
// frame state machine: header capture, running sum and result formation
// ----------------------------------------------------------------------------
module afrc_parser
  import afrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        emit,
  output result_t     res
);

  logic [3:0]  phase, phase_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] payload_left, payload_left_next;
  logic [7:0]  api_reg, api_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] dest_reg, dest_reg_next;
  logic [7:0]  opt_reg, opt_reg_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  sum_add;
  logic [15:0] left_dec;

  assign sum_add  = running_sum + rx_byte;
  assign left_dec = payload_left - 16'd1;

  always_comb begin
    phase_next        = phase;
    length_reg_next   = length_reg;
    payload_left_next = payload_left;
    api_reg_next      = api_reg;
    id_reg_next       = id_reg;
    dest_reg_next     = dest_reg;
    opt_reg_next      = opt_reg;
    running_sum_next  = running_sum;
    emit              = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.data_byte     = rx_byte;
    res.api_id        = api_reg;
    res.frame_id      = id_reg;
    res.dest_addr     = dest_reg;
    res.options       = opt_reg;
    res.frame_length  = length_reg;
    res.checksum_ok   = 1'b0;
    unique case (phase)
      PH_LEN_HI: begin
        length_reg_next = {rx_byte, 8'h00};
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next  = {length_reg[15:8], rx_byte};
        running_sum_next = 8'h00;
        phase_next       = PH_API;
      end
      PH_API: begin
        api_reg_next     = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        id_reg_next      = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_DEST_HI;
      end
      PH_DEST_HI: begin
        dest_reg_next    = {rx_byte, 8'h00};
        running_sum_next = sum_add;
        phase_next       = PH_DEST_LO;
      end
      PH_DEST_LO: begin
        dest_reg_next    = {dest_reg[15:8], rx_byte};
        running_sum_next = sum_add;
        phase_next       = PH_OPT;
      end
      PH_OPT: begin
        opt_reg_next     = rx_byte;
        running_sum_next = sum_add;
        if (length_reg > HEADER_LEN) begin
          payload_left_next = length_reg - HEADER_LEN;
          phase_next        = PH_PAYLOAD;
        end else begin
          payload_left_next = 16'd0;
          phase_next        = PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next  = sum_add;
        payload_left_next = left_dec;
        if (left_dec == 16'd0) begin
          phase_next = PH_CHECK;
        end
        emit = 1'b1;
      end
      PH_CHECK: begin
        emit            = 1'b1;
        res.kind        = KIND_END;
        res.data_byte   = 8'h00;
        res.checksum_ok = ((SUM_BASE - running_sum) == rx_byte);
        phase_next      = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      length_reg   <= 16'd0;
      payload_left <= 16'd0;
      api_reg      <= 8'd0;
      id_reg       <= 8'd0;
      dest_reg     <= 16'd0;
      opt_reg      <= 8'd0;
      running_sum  <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      length_reg   <= length_reg_next;
      payload_left <= payload_left_next;
      api_reg      <= api_reg_next;
      id_reg       <= id_reg_next;
      dest_reg     <= dest_reg_next;
      opt_reg      <= opt_reg_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ----- sv/afrc_checker.sv -----
// ----------------------------------------------------------------------------
// afrc_checker
// port-level checks of the api frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afrc_checker
  import afrc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       kind,
  input logic [7:0] data_byte,
  input logic       checksum_ok
);

  `ASSERT_CLK(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped")
  `ASSERT_CLK(a_ready_empty, clk, rst, !res_valid |-> rx_ready, "not ready while empty")
  `ASSERT_CLK(a_ok_only_end, clk, rst,
    res_valid && (kind == KIND_PAYLOAD) |-> !checksum_ok, "check flag on payload")
  `ASSERT_CLK(a_end_no_data, clk, rst,
    res_valid && (kind == KIND_END) |-> data_byte == 8'h00, "data on frame end")
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !res_valid, "result after reset")

endmodule

bind api_frame_receiver_checksum afrc_checker u_afrc_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .kind        (kind),
  .data_byte   (data_byte),
  .checksum_ok (checksum_ok)
);

// ----- test/afrc_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrc_frame_checker
// Watches the byte and result channels of the api frame receiver. It tracks
// the frame parse on every accepted byte, queues the payload and frame-end
// results that the byte must cause, and compares each accepted result with
// the oldest queued one.
// ----------------------------------------------------------------------------
module afrc_frame_checker
  import afrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  api_id,
  input  logic [7:0]  frame_id,
  input  logic [15:0] dest_addr,
  input  logic [7:0]  options,
  input  logic [15:0] frame_length,
  input  logic        checksum_ok,
  output int          mismatch_count,
  output int          results_owed
);

  logic [3:0]  parse_phase;
  logic [15:0] len_seen;
  logic [15:0] bytes_left;
  logic [7:0]  api_seen;
  logic [7:0]  id_seen;
  logic [15:0] dest_seen;
  logic [7:0]  opt_seen;
  logic [7:0]  byte_sum;
  result_t     results_due[$];

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  function automatic result_t frame_result(input logic k, input logic [7:0] d,
                                           input logic ok);
    result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.api_id       = api_seen;
    r.frame_id     = id_seen;
    r.dest_addr    = dest_seen;
    r.options      = opt_seen;
    r.frame_length = len_seen;
    r.checksum_ok  = ok;
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    case (parse_phase)
      PH_LEN_HI: begin
        len_seen = {b, 8'h00};
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_seen = {len_seen[15:8], b};
        byte_sum = 8'h00;
        parse_phase = PH_API;
      end
      PH_API: begin
        api_seen = b;
        byte_sum = byte_sum + b;
        parse_phase = PH_ID;
      end
      PH_ID: begin
        id_seen = b;
        byte_sum = byte_sum + b;
        parse_phase = PH_DEST_HI;
      end
      PH_DEST_HI: begin
        dest_seen = {b, 8'h00};
        byte_sum = byte_sum + b;
        parse_phase = PH_DEST_LO;
      end
      PH_DEST_LO: begin
        dest_seen = {dest_seen[15:8], b};
        byte_sum = byte_sum + b;
        parse_phase = PH_OPT;
      end
      PH_OPT: begin
        opt_seen = b;
        byte_sum = byte_sum + b;
        if (len_seen > HEADER_LEN) begin
          bytes_left = len_seen - HEADER_LEN;
          parse_phase = PH_PAYLOAD;
        end else begin
          bytes_left = 16'd0;
          parse_phase = PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        byte_sum = byte_sum + b;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) parse_phase = PH_CHECK;
        results_due.push_back(frame_result(KIND_PAYLOAD, b, 1'b0));
      end
      PH_CHECK: begin
        results_due.push_back(frame_result(KIND_END, 8'h00,
                                           (SUM_BASE - byte_sum) == b));
        parse_phase = PH_HUNT;
      end
      default: begin
        parse_phase = (b == START_BYTE) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      parse_phase = PH_HUNT;
      len_seen = '0;
      bytes_left = '0;
      api_seen = '0;
      id_seen = '0;
      dest_seen = '0;
      opt_seen = '0;
      byte_sum = '0;
      results_due.delete();
    end else begin
      // a result never belongs to the byte accepted at the same edge
      if (res_valid && res_ready) begin
        if (results_due.size() == 0) begin
          $error("result transaction with no result expected");
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("kind", 16'(want.kind), 16'(kind));
          compare_field("data_byte", 16'(want.data_byte), 16'(data_byte));
          compare_field("api_id", 16'(want.api_id), 16'(api_id));
          compare_field("frame_id", 16'(want.frame_id), 16'(frame_id));
          compare_field("dest_addr", want.dest_addr, dest_addr);
          compare_field("options", 16'(want.options), 16'(options));
          compare_field("frame_length", want.frame_length, frame_length);
          compare_field("checksum_ok", 16'(want.checksum_ok), 16'(checksum_ok));
        end
      end
      if (rx_valid && rx_ready) parse_rx_byte(rx_byte);
    end
    results_owed = results_due.size();
  end

endmodule

// ----- test/tb_api_frame_receiver_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_api_frame_receiver_checksum
// Feeds the api frame receiver with noise and whole frames: short and long
// lengths, start bytes inside payload, good and corrupted checksums. Runs
// under several sender idle and receiver stall mixes, with a checker beside
// the block doing the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_api_frame_receiver_checksum;
  import afrc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BYTES_PER_PASS = 390;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  api_id;
  logic [7:0]  frame_id;
  logic [15:0] dest_addr;
  logic [7:0]  options;
  logic [15:0] frame_length;
  logic        checksum_ok;

  int mismatch_count;
  int results_owed;
  int send_idle_pct;
  int recv_stall_pct;
  int frame_bytes_sent;
  int long_frames;
  int quiet_cycles;

  api_frame_receiver_checksum dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_ready(res_ready),
    .kind(kind), .data_byte(data_byte), .api_id(api_id), .frame_id(frame_id),
    .dest_addr(dest_addr), .options(options), .frame_length(frame_length),
    .checksum_ok(checksum_ok)
  );

  afrc_frame_checker u_frame_checker (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_ready(res_ready),
    .kind(kind), .data_byte(data_byte), .api_id(api_id), .frame_id(frame_id),
    .dest_addr(dest_addr), .options(options), .frame_length(frame_length),
    .checksum_ok(checksum_ok),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial res_ready = 1'b0;

  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_valid && rx_ready) || (res_valid && res_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!rx_ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 7) == 0) return START_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input logic [15:0] len, input logic [7:0] api,
                            input logic [7:0] id, input logic [15:0] dest,
                            input logic [7:0] opt, input bit rand_fill,
                            input logic [7:0] fill, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] csum;
    int n;
    sum = api + id + dest[15:8] + dest[7:0] + opt;
    send_byte(START_BYTE);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(api);
    send_byte(id);
    send_byte(dest[15:8]);
    send_byte(dest[7:0]);
    send_byte(opt);
    n = (len > HEADER_LEN) ? int'(len - HEADER_LEN) : 0;
    for (int i = 0; i < n; i++) begin
      b = rand_fill ? payload_byte() : fill;
      sum = sum + b;
      send_byte(b);
    end
    csum = SUM_BASE - sum;
    if (!good_sum) csum = csum ^ (8'h01 << $urandom_range(0, 7));
    send_byte(csum);
    frame_bytes_sent += 9 + n;
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom_range(0, 254));
      if (b >= START_BYTE) b = b + 8'd1;
      send_byte(b);
    end
  endtask

  task automatic send_random_frame();
    logic [15:0] len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2 && long_frames < 3) begin
      len = 16'(256 + $urandom_range(0, 8));
      long_frames++;
    end else if (r < 25) begin
      len = 16'($urandom_range(0, 5));
    end else begin
      len = 16'($urandom_range(6, 20));
    end
    send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
               1'b1, 8'h00, $urandom_range(0, 3) != 0);
  endtask

  // hold the sender off until the checker has nothing outstanding
  task automatic drain_results();
    rx_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'h00;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    frame_bytes_sent = 0;
    long_frames = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // bytes dropped while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // short length, all-zero header, good checksum
    send_frame(16'h0000, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b1);
    // all-ones header, start byte as payload, corrupted checksum
    send_frame(16'h0006, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, START_BYTE, 1'b0);

    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      frame_bytes_sent = 0;
      while (frame_bytes_sent < BYTES_PER_PASS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_random_frame();
      end
      drain_results();
    end

    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/afrc_pkg.sv
sv/afrc_parser.sv
sv/api_frame_receiver_checksum.sv
sv/afrc_checker.sv
test/afrc_frame_checker.sv
test/tb_api_frame_receiver_checksum.sv
